[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define SWS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sws assertion failed");

// Clocked check that also applies while reset is asserted.
`define SWS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("sws assertion failed");

`endif

[rtl/core/sws_pkg.sv]
// Types and constants of the stop-and-wait sender.
`timescale 1ns / 1ps

package sws_pkg;

  localparam int unsigned PAYLOAD_BYTES = 10;

  // Byte masks for the two payload words, derived from the payload size.
  localparam logic [63:0] LowMask = (PAYLOAD_BYTES >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF :
      ((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);
  localparam logic [15:0] HighMask = (PAYLOAD_BYTES <= 8) ? 16'h0000 :
      (PAYLOAD_BYTES >= 10) ? 16'hFFFF :
      16'((32'd1 << (8 * (PAYLOAD_BYTES - 8))) - 32'd1);

  localparam logic [1:0] OP_SEND     = 2'd0;
  localparam logic [1:0] OP_ACK      = 2'd1;
  localparam logic [1:0] OP_TIMEOUT  = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef enum logic [2:0] {
    ACT_IGNORED        = 3'd0,
    ACT_SENT           = 3'd1,
    ACT_RESENT_TIMEOUT = 3'd2,
    ACT_RESENT_BAD_ACK = 3'd3,
    ACT_ACK_OK         = 3'd4
  } action_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] seq_number;
    logic signed [31:0] length_word;
    logic signed [31:0] check_word;
    logic [63:0]        payload_low;
    logic [15:0]        payload_high;
  } in_item_t;

  typedef struct packed {
    action_e           action;
    logic              tx_seq;
    logic [3:0]        tx_length;
    logic signed [7:0] tx_check;
    logic [63:0]       tx_payload_low;
    logic [15:0]       tx_payload_high;
  } out_item_t;

endpackage

[rtl/core/sws_in_reg.sv]
// Input register stage of the stop-and-wait sender.
`timescale 1ns / 1ps

module sws_in_reg import sws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output in_item_t data_o
);

  logic     valid_q;
  in_item_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

[rtl/core/sws_out_reg.sv]
// Result register stage of the stop-and-wait sender.
`timescale 1ns / 1ps

module sws_out_reg import sws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  out_item_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t data_o
);

  logic      valid_q;
  out_item_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

[rtl/core/sws_engine.sv]
// Protocol state and per-item decision logic of the stop-and-wait sender.
`timescale 1ns / 1ps

module sws_engine import sws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  function automatic logic [7:0] fold64(logic [63:0] w);
    logic [7:0] x;
    x = 8'h00;
    for (int i = 0; i < 8; i++) begin
      x ^= w[8*i +: 8];
    end
    return x;
  endfunction

  function automatic logic [7:0] fold32(logic [31:0] w);
    return w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
  endfunction

  logic        seq_bit_q, seq_bit_d;
  logic        awaiting_q, awaiting_d;
  logic [3:0]  held_len_q, held_len_d;
  logic [63:0] held_low_q, held_low_d;
  logic [15:0] held_high_q, held_high_d;

  logic [31:0] len_u;
  logic        len_ok;
  logic        send_ok;
  logic [3:0]  emit_len;
  logic [63:0] emit_low;
  logic [15:0] emit_high;
  logic [7:0]  emit_x;
  logic [7:0]  ack_x;
  logic [31:0] ack_check;
  logic        ack_good;

  assign len_u   = $unsigned(item_i.length_word);
  assign len_ok  = (len_u >= 32'd1) && (len_u <= 32'(PAYLOAD_BYTES));
  assign send_ok = !awaiting_q && len_ok;

  // Emit either the fresh chunk or the held packet.
  assign emit_len  = send_ok ? len_u[3:0] : held_len_q;
  assign emit_low  = send_ok ? (item_i.payload_low & LowMask) : held_low_q;
  assign emit_high = send_ok ? (item_i.payload_high & HighMask) : held_high_q;
  assign emit_x    = {7'b0, seq_bit_q} ^ {4'b0, emit_len} ^ fold64(emit_low) ^
                     fold64({48'b0, emit_high});

  assign ack_x = fold32($unsigned(item_i.seq_number)) ^ fold32(len_u) ^
                 fold64(item_i.payload_low & LowMask) ^
                 fold64({48'b0, item_i.payload_high & HighMask});
  assign ack_check = {{24{ack_x[7]}}, ack_x};
  assign ack_good  = ($unsigned(item_i.check_word) == ack_check) &&
                     ($unsigned(item_i.seq_number) == {31'b0, seq_bit_q});

  always_comb begin
    out_item_t r;
    logic      emit;
    r           = '0;
    r.action    = ACT_IGNORED;
    emit        = 1'b0;
    seq_bit_d   = seq_bit_q;
    awaiting_d  = awaiting_q;
    held_len_d  = held_len_q;
    held_low_d  = held_low_q;
    held_high_d = held_high_q;
    case (item_i.opcode)
      OP_SEND: begin
        if (send_ok) begin
          held_len_d  = emit_len;
          held_low_d  = emit_low;
          held_high_d = emit_high;
          awaiting_d  = 1'b1;
          r.action    = ACT_SENT;
          emit        = 1'b1;
        end
      end
      OP_ACK: begin
        if (awaiting_q) begin
          if (ack_good) begin
            seq_bit_d  = !seq_bit_q;
            awaiting_d = 1'b0;
            r.action   = ACT_ACK_OK;
          end else begin
            r.action = ACT_RESENT_BAD_ACK;
            emit     = 1'b1;
          end
        end
      end
      OP_TIMEOUT: begin
        if (awaiting_q) begin
          r.action = ACT_RESENT_TIMEOUT;
          emit     = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      r.tx_seq          = seq_bit_q;
      r.tx_length       = emit_len;
      r.tx_check        = $signed(emit_x);
      r.tx_payload_low  = emit_low;
      r.tx_payload_high = emit_high;
    end
    result_o = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_bit_q  <= 1'b0;
      awaiting_q <= 1'b0;
      held_len_q <= 4'd0;
    end else if (fire_i) begin
      seq_bit_q  <= seq_bit_d;
      awaiting_q <= awaiting_d;
      held_len_q <= held_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      held_low_q  <= held_low_d;
      held_high_q <= held_high_d;
    end
  end

endmodule

[rtl/core/stop_and_wait_sender_top.sv]
// Top level of the stop-and-wait (alternating-bit) sender.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (out_item_t)
//
// Every input item yields exactly one result item once it is accepted; it
// passes through the input register and then the result register.
// Throughput is one item per clock unless out_ready_i stalls, with the
// decision logic (checksum XOR tree, one-bit state update) between registers.
// rst_ni clears the sequence bit, the waiting flag, the held length and both
// valid flags; held payload words are loaded by the first send.
// A stall on out_ready_i holds both stages; in_ready_o drops only when both
// registers are full and the result is not being taken.
`timescale 1ns / 1ps

module stop_and_wait_sender_top import sws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      stage_valid;
  in_item_t  stage_item;
  logic      result_ready;
  logic      fire;
  out_item_t result;

  // Hold the accepted item until the result register has room.
  sws_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (stage_valid),
    .ready_i (result_ready),
    .data_o  (stage_item)
  );

  // Advance protocol state only when the item moves into the result register.
  assign fire = stage_valid && result_ready;

  sws_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_item),
    .result_o (result)
  );

  // Hold the result until the consumer takes it.
  sws_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .ready_o (result_ready),
    .data_i  (result),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

[rtl/core/sws_checker.sv]
// Port-level checker for the stop-and-wait sender, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sws_checker import sws_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  logic out_stalled;
  logic no_tx_action;
  logic tx_fields_zero;
  logic tx_length_legal;

  assign out_stalled     = out_valid_o && !out_ready_i;
  assign no_tx_action    = (out_data_o.action == ACT_IGNORED) ||
                           (out_data_o.action == ACT_ACK_OK);
  assign tx_fields_zero  = (out_data_o.tx_length == 4'd0) && (out_data_o.tx_check == 8'sd0) &&
                           (out_data_o.tx_payload_low == 64'd0) &&
                           (out_data_o.tx_payload_high == 16'd0) && !out_data_o.tx_seq;
  assign tx_length_legal = (out_data_o.tx_length >= 4'd1) &&
                           (out_data_o.tx_length <= 4'(PAYLOAD_BYTES));

  `SWS_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |=> !out_valid_o)

  `SWS_ASSERT(a_out_hold, clk_i, rst_ni, out_stalled |=> out_valid_o && $stable(out_data_o))

  `SWS_ASSERT(a_ready_when_drained, clk_i, rst_ni, out_ready_i |-> in_ready_o)

  `SWS_ASSERT(a_silent_fields_zero, clk_i, rst_ni, out_valid_o && no_tx_action |-> tx_fields_zero)

  `SWS_ASSERT(a_sent_length_range, clk_i, rst_ni, out_valid_o && !no_tx_action |-> tx_length_legal)

endmodule

bind stop_and_wait_sender_top sws_checker u_sws_checker (.*);
